// ----- hw/rtl/icfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfm_pkg: shared definitions for the input capture frequency meter
// Field widths, event codes, controller states and unit status type.
// ----------------------------------------------------------------------------
package icfm_pkg;

    // field and register widths
    localparam int OPCODE_W  = 2;
    localparam int CAPTURE_W = 16;
    localparam int CPO_W     = 16;
    localparam int REFCLK_W  = 32;
    localparam int FREQ_W    = 32;
    localparam int OVF_W     = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [CPO_W-1:0]    CPO_RESET    = 16'hFFFF;
    localparam logic [REFCLK_W-1:0] REFCLK_RESET = 32'd84000000;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_OVERFLOW = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE_CLOCK_HZ  = 1'd1;

    // event codes carried on the input tuser
    typedef enum logic [OPCODE_W-1:0] {
        OP_OVERFLOW      = 2'd0,
        OP_CAPTURE       = 2'd1,
        OP_OTHER_CHANNEL = 2'd2,
        OP_OTHER_TIMER   = 2'd3
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DIVIDE,
        ST_STORE
    } state_t;

    // status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ----- hw/rtl/icfm_period.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfm_period: bit-serial period computation
// Computes capture + overflows * counts_per_overflow - first timestamp,
// 32-bit wrapping, taking one overflow-count bit per cycle.
// ----------------------------------------------------------------------------
module icfm_period
    import icfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CAPTURE_W-1:0] capture_value,
    input  logic [CAPTURE_W-1:0] first_timestamp,
    input  logic [OVF_W-1:0]     overflow_count,
    input  logic [CPO_W-1:0]     counts_per_overflow,
    output unit_stat_t           stat,
    output logic [FREQ_W-1:0]    diff
);

    localparam int STEPS   = OVF_W;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam int MCAND_W = CPO_W + OVF_W;

    logic [FREQ_W-1:0]  acc_reg, acc_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [OVF_W-1:0]   mplier_reg, mplier_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // shift-add datapath and step counter
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = FREQ_W'(capture_value) - FREQ_W'(first_timestamp);
            mcand_next  = MCAND_W'(counts_per_overflow);
            mplier_next = overflow_count;
            cnt_next    = CNT_W'(STEPS);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + FREQ_W'(mcand_reg);
            end
            mcand_next  = {mcand_reg[MCAND_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[OVF_W-1:1]};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign diff      = acc_reg;

endmodule

// ----- hw/rtl/icfm_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfm_divider: restoring divider, one quotient bit per cycle
// A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module icfm_divider
    import icfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FREQ_W-1:0] dividend,
    input  logic [FREQ_W-1:0] divisor,
    output unit_stat_t        stat,
    output logic [FREQ_W-1:0] quotient
);

    localparam int CNT_W = $clog2(FREQ_W + 1);

    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] quo_reg, quo_next;
    logic [FREQ_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [FREQ_W:0]   shifted;
    logic [FREQ_W:0]   trial;

    // partial remainder with the next dividend bit shifted in
    assign shifted = {rem_reg, quo_reg[FREQ_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    // one restoring step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(FREQ_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[FREQ_W])
            begin
                rem_next = trial[FREQ_W-1:0];
                quo_next = {quo_reg[FREQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[FREQ_W-1:0];
                quo_next = {quo_reg[FREQ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- hw/rtl/input_capture_frequency_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_capture_frequency_meter: frequency from two timer input captures
//
//   channel   direction  handshake                  content
//   s_axis    in         tvalid / tready            tuser opcode, tdata capture
//   m_axis    out        tvalid / tready            tdata frequency, tuser zero_period
//   cfg       in         cfg_wr_en (no wait)        cfg_addr, cfg_wdata
//
// Overflow, ignored and first-capture items are taken without holding off input.
// A second capture's result is computed by the bit-serial overflow product,
// then by the one-bit-per-cycle restoring divider, and is then stored in the
// output register; the next item is taken once the controller returns to idle.
// Input is held off while a second capture is computed and while its result
// waits for a full output register to drain.
// Reset is asynchronous, active low, and returns the controller state, capture
// state, configuration registers and output valid to their defaults.
// ----------------------------------------------------------------------------
module input_capture_frequency_meter
    import icfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] capture_value
    input  logic [1:0]            s_axis_tuser,   // [1:0] opcode
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [31:0] frequency
    output logic [0:0]            m_axis_tuser,   // [0] zero_period
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    state_t                state_reg, state_next;
    logic                  awaiting_reg, awaiting_next;
    logic [OVF_W-1:0]      ovf_cnt_reg, ovf_cnt_next;
    logic [CAPTURE_W-1:0]  first_ts_reg, first_ts_next;
    logic [CPO_W-1:0]      cpo_reg;
    logic [REFCLK_W-1:0]   refclk_reg;
    logic                  zero_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]     out_freq_reg;
    logic                  out_zero_reg;

    logic                  accept;
    logic                  period_start;
    logic                  div_start;
    logic                  out_load;
    op_t                   opcode;
    unit_stat_t            period_stat;
    unit_stat_t            div_stat;
    logic [FREQ_W-1:0]     period_diff;
    logic [FREQ_W-1:0]     div_quotient;

    assign opcode = op_t'(s_axis_tuser);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_CAPTURE && awaiting_reg)
                begin
                    state_next = ST_PERIOD;
                end
            end
            ST_PERIOD:
            begin
                if (period_stat.done)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        period_start  = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                period_start  = s_axis_tvalid && opcode == OP_CAPTURE && awaiting_reg;
            end
            ST_PERIOD:
            begin
                div_start = period_stat.done;
            end
            ST_DIVIDE:
            begin
                out_load = 1'b0;
            end
            ST_STORE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // capture state update
    always_comb
    begin
        awaiting_next = awaiting_reg;
        ovf_cnt_next  = ovf_cnt_reg;
        first_ts_next = first_ts_reg;
        if (accept)
        begin
            unique case (opcode)
                OP_OVERFLOW:
                begin
                    ovf_cnt_next = ovf_cnt_reg + OVF_W'(1);
                end
                OP_CAPTURE:
                begin
                    if (!awaiting_reg)
                    begin
                        ovf_cnt_next  = '0;
                        first_ts_next = s_axis_tdata;
                        awaiting_next = 1'b1;
                    end
                    else
                    begin
                        awaiting_next = 1'b0;
                    end
                end
                OP_OTHER_CHANNEL, OP_OTHER_TIMER:
                begin
                    awaiting_next = awaiting_reg;
                end
                default:
                begin
                    awaiting_next = awaiting_reg;
                end
            endcase
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state, capture state, output valid and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            awaiting_reg  <= 1'b0;
            ovf_cnt_reg   <= '0;
            first_ts_reg  <= '0;
            cpo_reg       <= CPO_RESET;
            refclk_reg    <= REFCLK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            awaiting_reg  <= awaiting_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            first_ts_reg  <= first_ts_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    REG_COUNTS_PER_OVERFLOW:
                    begin
                        cpo_reg <= cfg_wdata[CPO_W-1:0];
                    end
                    REG_REFERENCE_CLOCK_HZ:
                    begin
                        refclk_reg <= cfg_wdata[REFCLK_W-1:0];
                    end
                    default:
                    begin
                        cpo_reg <= cpo_reg;
                    end
                endcase
            end
        end
    end

    // zero-period flag and result register
    always_ff @(posedge clk)
    begin
        if (period_stat.done)
        begin
            zero_reg <= (period_diff == '0);
        end
        if (out_load)
        begin
            out_freq_reg <= div_quotient;
            out_zero_reg <= zero_reg;
        end
    end

    // bit-serial period unit
    icfm_period u_period (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (period_start),
        .capture_value       (s_axis_tdata),
        .first_timestamp     (first_ts_reg),
        .overflow_count      (ovf_cnt_reg),
        .counts_per_overflow (cpo_reg),
        .stat                (period_stat),
        .diff                (period_diff)
    );

    // serial divider
    icfm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (refclk_reg),
        .divisor  (period_diff),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_freq_reg;
    assign m_axis_tuser[0] = out_zero_reg;

endmodule

// ----- hw/rtl/icfm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icfm_checker: port-level checks for the frequency meter
// Watches the top level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module icfm_checker
    import icfm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [31:0]           m_axis_tdata,
    input logic [0:0]            m_axis_tuser
);

    // a zero period always reports an all-ones frequency
    a_zero_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '1)
        else $error("zero period without all-ones frequency");

    // a new result only appears after the input was held off for computation
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a computation phase");

    // input is only held off after a capture item was taken
    a_stall_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |->
            $past(s_axis_tvalid) && $past(s_axis_tuser) == OP_CAPTURE)
        else $error("input stalled without a capture item");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind input_capture_frequency_meter icfm_checker u_icfm_checker (.*);
